// ----- sv/sss_pkg.sv -----
// shared types and constants for the substring search block
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

  localparam int BYTE_W   = 8;
  localparam int PIDX_W   = 6;
  localparam int LEN_W    = 7;
  localparam int OFFS_W   = 16;
  localparam int RES_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [BYTE_W-1:0]       byte_t;
  typedef logic [PIDX_W-1:0]       pidx_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [OFFS_W-1:0]       offs_t;
  typedef logic signed [RES_W-1:0] res_t;

  localparam res_t NO_MATCH = '1;
  localparam byte_t TEXT_END = '0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_START_OFFSET   = 1'b1
  } reg_idx_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic  step;
    logic  clear;
    logic  load;
    pidx_t load_index;
    byte_t data;
    len_t  len;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/sss_ifs.sv -----
// request channel interfaces for text/pattern input and match results
`timescale 1ns / 1ps
`default_nettype none
interface sss_in_if;
  import sss_pkg::*;
  logic  valid;
  logic  ready;
  logic  opcode;
  pidx_t pattern_index;
  byte_t data_byte;
  logic  last_byte;
  modport source (output valid, output opcode, output pattern_index, output data_byte,
                  output last_byte, input ready);
  modport sink (input valid, input opcode, input pattern_index, input data_byte,
                input last_byte, output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;
  logic valid;
  logic ready;
  res_t match_offset;
  modport source (output valid, output match_offset, input ready);
  modport sink (input valid, input match_offset, output ready);
endinterface
`default_nettype wire

// ----- sv/sss_cell.sv -----
// one pattern cell: stored byte and partial match bit
`timescale 1ns / 1ps
`default_nettype none
module sss_cell #(
  parameter int J = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sss_pkg::cell_ctrl_t ctrl,
  input  wire logic               prev_bit,
  output logic                    match_bit,
  output logic                    hit
);
  import sss_pkg::*;

  byte_t pat;
  logic  match_bit_next;
  logic  active;
  logic  is_last;

  assign active  = int'(ctrl.len) > J;
  assign is_last = int'(ctrl.len) == J + 1;

  always_comb begin
    match_bit_next = match_bit;
    if (ctrl.step) begin
      match_bit_next = active && prev_bit && (pat == ctrl.data);
    end
  end

  assign hit = ctrl.step && is_last && match_bit_next;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match_bit <= 1'b0;
    end else begin
      match_bit <= match_bit_next;
    end
  end

  // pattern byte, undefined until loaded
  always_ff @(posedge clk) begin
    if (ctrl.load && int'(ctrl.load_index) == J) begin
      pat <= ctrl.data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sss_out_buf.sv -----
// two-entry result buffer: output register plus skid register
`timescale 1ns / 1ps
`default_nettype none
module sss_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sss_pkg::res_t push_data,
  output logic               space,
  sss_out_if.source          result
);
  import sss_pkg::*;

  logic ov;
  logic sv;
  res_t od;
  res_t sd;
  logic pop;

  assign pop   = ov && result.ready;
  assign space = !sv;
  assign result.valid        = ov;
  assign result.match_offset = od;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (pop) begin
      if (sv) begin
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (!ov) begin
      ov <= push;
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && sv) begin
      od <= sd;
    end else if ((pop && !sv) || !ov) begin
      od <= push_data;
    end
    if (ov && !pop && push) begin
      sd <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/substring_search_from_offset.sv -----
// top level of the streaming first-occurrence substring search
//
//   channel  dir  payload                                          role
//   text     in   opcode, pattern_index, data_byte, last_byte      pattern loads, text bytes
//   result   out  match_offset (17b signed, -1 when no match)      one per text
//   cfg      in   cfg_we, cfg_index, cfg_data                      pattern_length, start_offset
//
// one request per cycle while ready is high; the result that a text byte decides
// is registered in the output buffer. the rate is set by the cell row, which
// compares every pattern byte with the incoming byte in the same cycle.
// the two-entry output buffer keeps text requests flowing while one result
// waits; ready drops only when both entries are full.
// synchronous reset clears the match bits, position and flags; pattern bytes
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module substring_search_from_offset #(
  parameter int PATTERN_MAX = 64,
  parameter int TEXT_MAX    = 65536
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  sss_in_if.sink                                   text,
  sss_out_if.source                                result,
  input  wire logic                                cfg_we,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sss_pkg::*;

  localparam int POS_W = $clog2(TEXT_MAX);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_MAX - 1);

  // configuration registers
  len_t  pattern_length;
  offs_t start_offset;

  // per-text state
  logic [POS_W-1:0] pos;
  logic             answer_given;
  logic             text_ended;

  logic             space;
  logic             accept;
  logic             is_text;
  logic             live;
  logic             byte_step;
  len_t             len_eff;
  logic             seed;
  cell_ctrl_t       ctrl;
  logic [PATTERN_MAX-1:0] mbit;
  logic [PATTERN_MAX-1:0] hits;
  logic             hit;
  logic             empty_hit;
  logic             found;
  logic             res_push;
  res_t             res_data;
  logic [POS_W-1:0] start_pos;
  logic [POS_W+RES_W-1:0] start_wide;

  assign text.ready = space;
  assign accept     = text.valid && text.ready;
  assign is_text    = text.opcode == OP_TEXT;
  // a text byte still counts until the answer is out or a zero byte ends it
  assign live       = accept && is_text && !answer_given && !text_ended;
  assign byte_step  = live && (text.data_byte != TEXT_END);

  // lengths above the cell count use the whole row
  assign len_eff = (32'(pattern_length) > 32'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : pattern_length;
  assign seed    = 32'(pos) >= 32'(start_offset);

  always_comb begin
    ctrl.step       = byte_step && (len_eff != '0);
    ctrl.clear      = accept && is_text && text.last_byte;
    ctrl.load       = accept && !is_text;
    ctrl.load_index = text.pattern_index;
    ctrl.data       = text.data_byte;
    ctrl.len        = len_eff;
  end

  // the cell row: each cell hands its match bit to the next one
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic prev_bit;
    if (j == 0) begin : g_head
      assign prev_bit = seed;
    end else begin : g_link
      assign prev_bit = mbit[j-1];
    end
    sss_cell #(.J(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_bit  (prev_bit),
      .match_bit (mbit[j]),
      .hit       (hits[j])
    );
  end

  assign hit       = |hits;
  // empty pattern matches at the first position at or past the offset
  assign empty_hit = byte_step && (len_eff == '0) && seed;
  assign found     = hit || empty_hit;

  // match start, low bits of the position less the pattern length minus one
  assign start_pos  = empty_hit ? pos : pos - POS_W'(len_eff - len_t'(1));
  assign start_wide = {RES_W'(0), start_pos};

  assign res_push = found || (accept && is_text && text.last_byte && !answer_given);
  assign res_data = found ? res_t'(start_wide[RES_W-1:0]) : NO_MATCH;

  sss_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .space     (space),
    .result    (result)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      start_offset   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // position, answer and end flags
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      pos          <= '0;
      answer_given <= 1'b0;
      text_ended   <= 1'b0;
    end else begin
      if (live && (text.data_byte == TEXT_END)) begin
        text_ended <= 1'b1;
      end
      if (found) begin
        answer_given <= 1'b1;
      end
      // position saturates at the last text slot
      if (byte_step && (pos != POS_LAST)) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // skid entry only fills behind a waiting output entry
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    u_out.sv |-> u_out.ov)
    else $error("skid entry valid while output entry empty");

  // results come only from text requests
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (accept && is_text))
    else $error("result pushed without a text request");

  // a last byte with no earlier answer always gives a result
  a_last_res: assert property (@(posedge clk) disable iff (rst)
    (accept && is_text && text.last_byte && !answer_given) |-> res_push)
    else $error("text ended without a result");

  // per-text state is cleared after the last byte
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && is_text && text.last_byte) |=> (!answer_given && !text_ended && pos == '0))
    else $error("per-text state not cleared after last byte");

endmodule
`default_nettype wire
